/* hw/rtl/nibble_rle_bit_packer_macros.svh */
// Assertion macros shared by the nibble run-length packer RTL.
`ifndef NIBBLE_RLE_BIT_PACKER_MACROS_SVH
`define NIBBLE_RLE_BIT_PACKER_MACROS_SVH

// Checked on every rising edge of clk_i, skipped while reset is asserted.
`define NRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define NRBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/nrbp_pkg.sv */
// Package of constants, types and token helpers for the nibble run-length packer.
package nrbp_pkg;

  localparam int unsigned PIX_W         = 4;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned MAX_RUN_EXTRA = 31;
  localparam int unsigned CAP_W         = 16;
  localparam int unsigned CAP_RESET     = 19200;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned FILL_W        = 3;

  localparam int unsigned LIT_LEN = 1 + PIX_W;
  localparam int unsigned RUN_LEN = 1 + PIX_W + COUNT_BITS;
  localparam int unsigned TOK_W   = RUN_LEN;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned BITS_W  = 32;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_OUT_CAP = 1'b0;

  localparam int unsigned RES_MAX   = 3;
  localparam int unsigned RES_IDX_W = 2;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;
  localparam int unsigned QCNT_W    = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              ovf;
  } res_t;

  typedef struct packed {
    res_t [RES_MAX-1:0]   res;
    logic [RES_IDX_W-1:0] num;
  } pkt_t;

  // Token bits in send order: bit 0 of the result goes out first.
  function automatic logic [TOK_W-1:0] tok_stream(input logic [PIX_W-1:0]      val,
                                                  input logic [COUNT_BITS-1:0] extra);
    logic [TOK_W-1:0]   word;
    logic [LIT_LEN-1:0] lit;
    logic [TOK_W-1:0]   s;
    word = {1'b1, val, extra};
    lit  = {1'b0, val};
    s    = '0;
    if (extra != '0) begin
      for (int k = 0; k < TOK_W; k++) begin
        s[k] = word[TOK_W-1-k];
      end
    end else begin
      for (int k = 0; k < LIT_LEN; k++) begin
        s[k] = lit[LIT_LEN-1-k];
      end
    end
    return s;
  endfunction

  function automatic logic [LEN_W-1:0] tok_len(input logic [COUNT_BITS-1:0] extra);
    return (extra != '0) ? LEN_W'(RUN_LEN) : LEN_W'(LIT_LEN);
  endfunction

endpackage

/* hw/rtl/nibble_rle_bit_packer.sv */
// Top level of the nibble run-length packer: tokenizer, bit packer and result queue.
//
// Usage: pixels enter on the input channel (in_valid_i / in_stall_o with pixel_i and
// frame_end_i), one word per pixel in raster order; frame_end_i marks the last pixel.
// Code bytes leave on the output channel (out_valid_o / out_stall_i) with out_byte_o,
// last_byte_o and overflow_o. The earliest code bit sits in bit 0 of each byte.
// An accepted pixel lands in an input register; once the queue has a free packet entry,
// one pass of logic closes runs, packs tokens and writes up to three result words as
// one packet into a four-entry queue, which feeds the output channel; the packet
// drains one word per cycle while the receiver does not stall.
// The input side takes one pixel per cycle as long as the queue has a free packet
// entry; pixels that yield no byte use no entry. If the receiver stalls, the queue
// fills and in_stall_o rises once it is full and a pixel waits in the input register.
// The capacity register (APB, byte address 0) limits coded bytes per frame; beyond it
// bytes are dropped and the frame closes with a marker word (byte 0, last, overflow).
// Reset empties the queue and input register, clears all run and packing state, and
// sets the capacity to 19200 bytes.
module nibble_rle_bit_packer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [nrbp_pkg::PIX_W-1:0]         pixel_i,
  input  logic                               frame_end_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [nrbp_pkg::BYTE_W-1:0]        out_byte_o,
  output logic                               last_byte_o,
  output logic                               overflow_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [nrbp_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [nrbp_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [nrbp_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import nrbp_pkg::*;

  `include "nibble_rle_bit_packer_macros.svh"

  // Configuration.
  logic [CAP_W-1:0] cap_q;
  logic             cfg_hit;

  // Input register.
  logic             in_vld_q, in_vld_d;
  logic [PIX_W-1:0] pix_q;
  logic             fend_q;
  logic             take, fire;

  // Run and packing state.
  logic [PIX_W-1:0]      val_q, val_d;
  logic [COUNT_BITS-1:0] ext_q, ext_d;
  logic                  have_q, have_d;
  logic [BYTE_W-1:0]     acc_q, acc_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [CAP_W-1:0]      sent_q, sent_d;
  logic                  full_q, full_d;

  // Pass logic.
  logic                  close_a;
  logic [PIX_W-1:0]      nval;
  logic [COUNT_BITS-1:0] next;
  logic [TOK_W-1:0]      bits_a, bits_b;
  logic [LEN_W-1:0]      len_a, len_b, shift_b, total;
  logic [BITS_W-1:0]     stream;
  logic [RES_IDX_W-1:0]  full_bytes, n_coded, n_emit;
  logic [CAP_W-1:0]      room;
  logic                  full_any, marker;
  pkt_t                  pkt;

  // Result queue.
  pkt_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic [RES_IDX_W-1:0] sub_q;
  pkt_t              head;
  res_t              cur;
  logic              push, pop, pop_last;

  // APB register access; the register index is carried by paddr[2].
  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == REG_OUT_CAP);
  assign prdata  = cfg_hit ? {{(APB_DATA_W-CAP_W){1'b0}}, cap_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // The pass fires whenever a pixel waits and the queue has a free packet slot.
  assign fire       = in_vld_q && (cnt_q != QCNT_W'(QDEPTH));
  assign in_stall_o = in_vld_q && !fire;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (take) begin
      in_vld_d = 1'b1;
    end else if (fire) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pix_q  <= pixel_i;
      fend_q <= frame_end_i;
    end
  end

  // Run tracking: a pixel either starts, extends or closes the held run. At frame end
  // the run that is then held is closed as a second token.
  always_comb begin
    close_a = 1'b0;
    nval    = pix_q;
    next    = '0;
    if (have_q && (pix_q == val_q) && (ext_q < COUNT_BITS'(MAX_RUN_EXTRA))) begin
      nval = val_q;
      next = ext_q + 1'b1;
    end else if (have_q) begin
      close_a = 1'b1;
    end
    bits_a  = close_a ? tok_stream(val_q, ext_q) : '0;
    len_a   = close_a ? tok_len(ext_q) : '0;
    bits_b  = fend_q ? tok_stream(nval, next) : '0;
    len_b   = fend_q ? tok_len(next) : '0;
    shift_b = LEN_W'(fill_q) + len_a;
    total   = shift_b + len_b;
    // Bits above the fill level of the accumulator are always zero.
    stream  = BITS_W'(acc_q)
            | (BITS_W'(bits_a) << fill_q)
            | (BITS_W'(bits_b) << shift_b);
  end

  // Byte counting and capacity. At most three bytes come out of one pass: a closed
  // token of ten bits and a frame-end literal, or a single frame-end token, on top
  // of at most seven held bits, with the partial byte padded at frame end.
  always_comb begin
    full_bytes = total[LEN_W-1:FILL_W];
    n_coded    = full_bytes + RES_IDX_W'(fend_q && (total[FILL_W-1:0] != '0));
    room       = (sent_q < cap_q) ? (cap_q - sent_q) : '0;
    n_emit     = (room >= CAP_W'(n_coded)) ? n_coded : room[RES_IDX_W-1:0];
    full_any   = full_q || (n_emit != n_coded);
    marker     = fend_q && full_any;

    for (int i = 0; i < RES_MAX; i++) begin
      pkt.res[i].data = stream[i*BYTE_W +: BYTE_W];
      pkt.res[i].last = 1'b0;
      pkt.res[i].ovf  = 1'b0;
      if (marker && (RES_IDX_W'(i) == n_emit)) begin
        pkt.res[i].data = '0;
        pkt.res[i].last = 1'b1;
        pkt.res[i].ovf  = 1'b1;
      end else if (fend_q && !marker && (RES_IDX_W'(i + 1) == n_emit)) begin
        pkt.res[i].last = 1'b1;
      end
    end
    pkt.num = n_emit + RES_IDX_W'(marker);
  end

  // Next state of the coder.
  always_comb begin
    val_d  = nval;
    ext_d  = next;
    have_d = 1'b1;
    fill_d = total[FILL_W-1:0];
    sent_d = sent_q + CAP_W'(n_emit);
    full_d = full_any;
    case (full_bytes)
      2'd0:    acc_d = stream[0*BYTE_W +: BYTE_W];
      2'd1:    acc_d = stream[1*BYTE_W +: BYTE_W];
      2'd2:    acc_d = stream[2*BYTE_W +: BYTE_W];
      default: acc_d = stream[3*BYTE_W +: BYTE_W];
    endcase
    if (fend_q) begin
      val_d  = '0;
      ext_d  = '0;
      have_d = 1'b0;
      acc_d  = '0;
      fill_d = '0;
      sent_d = '0;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      ext_q  <= '0;
      have_q <= 1'b0;
      acc_q  <= '0;
      fill_q <= '0;
      sent_q <= '0;
      full_q <= 1'b0;
    end else if (fire) begin
      val_q  <= val_d;
      ext_q  <= ext_d;
      have_q <= have_d;
      acc_q  <= acc_d;
      fill_q <= fill_d;
      sent_q <= sent_d;
      full_q <= full_d;
    end
  end

  // Result queue: at most one packet per pass, drained one word per cycle while out_stall_i is low.
  assign push     = fire && (pkt.num != '0);
  assign head     = q_mem[rd_q];
  assign out_valid_o = (cnt_q != '0);
  assign pop      = out_valid_o && !out_stall_i;
  assign pop_last = pop && (sub_q == (head.num - 1'b1));

  always_comb begin
    case (sub_q)
      2'd0:    cur = head.res[0];
      2'd1:    cur = head.res[1];
      2'd2:    cur = head.res[2];
      default: cur = head.res[0];
    endcase
  end

  assign out_byte_o  = cur.data;
  assign last_byte_o = cur.last;
  assign overflow_o  = cur.ovf;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= pkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_last) begin
        rd_q  <= rd_q + 1'b1;
        sub_q <= '0;
      end else if (pop) begin
        sub_q <= sub_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop_last);
    end
  end

  `NRBP_ASSERT(a_cnt_bound, cnt_q <= QCNT_W'(QDEPTH), "result queue overfilled")
  `NRBP_ASSERT(a_sub_in_pkt, out_valid_o |-> (sub_q < head.num),
               "word index beyond packet")
  `NRBP_ASSERT(a_stall_full, in_stall_o |-> (cnt_q == QCNT_W'(QDEPTH)),
               "stall with free queue slot")
  `NRBP_ASSERT(a_frame_clear,
               (fire && fend_q) |=> (!have_q && fill_q == '0 && sent_q == '0),
               "coder state not cleared after frame end")
  `NRBP_ASSERT(a_marker_shape,
               (out_valid_o && overflow_o) |-> (last_byte_o && out_byte_o == '0),
               "malformed truncation marker")

endmodule

/* test/tb.sv */
// Self-checking testbench for the nibble run-length bit packer.
`timescale 1ns / 1ps

module tb;
  import nrbp_pkg::*;

  // One word on the pixel channel, plus the code words it must produce when
  // the directed table spells them out (typed set). Other words are checked
  // against the packer model below.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             fend;
    logic             typed;
    logic [1:0]       n;
    res_t             w0;
    res_t             w1;
  } pixel_word_t;

  localparam int unsigned CYC_LIMIT = 200000;
  localparam int unsigned MAX_NOTES = 40;
  localparam logic [APB_ADDR_W-1:0] CAP_ADDR = APB_ADDR_W'(4 * int'(REG_OUT_CAP));
  localparam res_t NO_WORD = '0;

  // Directed stimulus. Rows from DIR_CAP_ZERO_AT on run with a capacity of
  // zero, rows from DIR_CAP_ONE_AT on with a capacity of one byte.
  localparam int DIR_N           = 21;
  localparam int DIR_CAP_ZERO_AT = 14;
  localparam int DIR_CAP_ONE_AT  = 18;

  pixel_word_t dir_tab [DIR_N] = '{
    // A lone 0xF pixel: literal 0,1111 packed from bit 0 gives 0x1E.
    {4'hF, 1'b1, 1'b1, 2'd1, {8'h1E, 1'b1, 1'b0}, NO_WORD},
    // A lone zero pixel: an all-zero literal, padded.
    {4'h0, 1'b1, 1'b1, 2'd1, {8'h00, 1'b1, 1'b0}, NO_WORD},
    // Two pixels of 0xA: the first holds, the second closes a run token
    // 1,1010,00001 that spills two bits into a padded second byte.
    {4'hA, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {4'hA, 1'b1, 1'b1, 2'd2, {8'h0B, 1'b0, 1'b0}, {8'h02, 1'b1, 1'b0}},
    // Mixed runs and literals, then alternating extremes.
    {4'h3, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h3, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h3, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h7, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h7, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h2, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'hF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'h0, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'hF, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'hF, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    // Zero capacity: every byte is dropped and only the truncation marker
    // comes out at frame end.
    {4'h1, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {4'h2, 1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {4'h3, 1'b1, 1'b1, 2'd1, {8'h00, 1'b1, 1'b1}, NO_WORD},
    {4'h5, 1'b1, 1'b1, 2'd1, {8'h00, 1'b1, 1'b1}, NO_WORD},
    // Capacity of one byte: one coded byte, then the marker.
    {4'hA, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'hB, 1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {4'hC, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD}
  };

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [PIX_W-1:0]      pixel_i     = '0;
  logic                  frame_end_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [BYTE_W-1:0]     out_byte_o;
  logic                  last_byte_o;
  logic                  overflow_o;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [APB_ADDR_W-1:0] paddr       = '0;
  logic [APB_DATA_W-1:0] pwdata      = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  nibble_rle_bit_packer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pixel_i     (pixel_i),
    .frame_end_i (frame_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o),
    .overflow_o  (overflow_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  int unsigned cyc   = 0;
  int unsigned n_bad = 0;

  pixel_word_t pixel_q [$];  // pixels waiting to be sent
  pixel_word_t pix_on_bus;   // the pixel word currently offered
  res_t        code_q  [$];  // code words still owed by the block
  res_t        step_q  [$];  // code words of the pixel being modeled

  // Packer model state: capacity register, open run and partial byte.
  logic [CAP_W-1:0]      cap_reg   = CAP_W'(CAP_RESET);
  logic [PIX_W-1:0]      run_val   = '0;
  logic [COUNT_BITS-1:0] run_extra = '0;
  logic                  run_open  = 1'b0;
  logic [BYTE_W-1:0]     pack_acc  = '0;
  int                    pack_fill = 0;
  logic [CAP_W-1:0]      sent_cnt  = '0;
  logic                  cap_hit   = 1'b0;

  task automatic note_mismatch(input string what);
    if (n_bad < MAX_NOTES) $display("tb: mismatch at cycle %0d: %s", cyc, what);
    n_bad++;
  endtask

  // A byte counts against the capacity; beyond it the byte is lost and the
  // frame is marked as truncated.
  function automatic void put_code_byte(input logic [BYTE_W-1:0] b);
    if (sent_cnt < cap_reg) begin
      step_q.push_back({b, 1'b0, 1'b0});
      sent_cnt++;
    end else begin
      cap_hit = 1'b1;
    end
  endfunction

  // Bits go out MSB first and fill each byte from bit 0 upward.
  function automatic void pack_bits(input logic [TOK_W-1:0] bits, input int nbits);
    for (int i = nbits - 1; i >= 0; i--) begin
      pack_acc[pack_fill] = bits[i];
      pack_fill++;
      if (pack_fill == BYTE_W) begin
        put_code_byte(pack_acc);
        pack_acc  = '0;
        pack_fill = 0;
      end
    end
  endfunction

  function automatic void close_run();
    if (run_extra != '0) begin
      pack_bits({1'b1, run_val, run_extra}, RUN_LEN);
    end else begin
      pack_bits(TOK_W'({1'b0, run_val}), LIT_LEN);
    end
  endfunction

  // Works out the code words that one accepted pixel releases and queues
  // them, or the typed words of a directed row instead.
  function automatic void code_pixel(input pixel_word_t w);
    step_q.delete();
    if (!run_open) begin
      run_val   = w.pix;
      run_extra = '0;
      run_open  = 1'b1;
    end else if (w.pix == run_val && run_extra < MAX_RUN_EXTRA) begin
      run_extra++;
    end else begin
      close_run();
      run_val   = w.pix;
      run_extra = '0;
    end
    if (w.fend) begin
      close_run();
      if (pack_fill != 0) put_code_byte(pack_acc);
      if (cap_hit) begin
        step_q.push_back({8'h00, 1'b1, 1'b1});
      end else if (step_q.size() > 0) begin
        step_q[step_q.size() - 1].last = 1'b1;
      end
      run_val   = '0;
      run_extra = '0;
      run_open  = 1'b0;
      pack_acc  = '0;
      pack_fill = 0;
      sent_cnt  = '0;
      cap_hit   = 1'b0;
    end
    if (w.typed) begin
      if (w.n > 0) code_q.push_back(w.w0);
      if (w.n > 1) code_q.push_back(w.w1);
    end else begin
      foreach (step_q[k]) code_q.push_back(step_q[k]);
    end
  endfunction

  // Both sides idle now and then, except in every third stretch of cycles,
  // where they run flat out.
  function automatic logic take_break();
    if ((cyc / 600) % 3 == 1) return 1'b0;
    return $urandom_range(99) < 18;
  endfunction

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CYC_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Pixel sender. A word stays on the bus, unchanged, until it is taken;
  // the next word or an idle cycle follows in the same step.
  always @(posedge clk_i) begin : send_pixels
    logic took;
    took = rst_ni && in_valid_i && !in_stall_o;
    if (took) code_pixel(pix_on_bus);
    if (!in_valid_i || took) begin
      if (pixel_q.size() > 0 && !take_break()) begin
        pix_on_bus = pixel_q.pop_front();
        in_valid_i  <= 1'b1;
        pixel_i     <= pix_on_bus.pix;
        frame_end_i <= pix_on_bus.fend;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= take_break();
  end

  // Code word checker: every word taken is matched against the oldest word
  // still owed, field by field.
  always @(posedge clk_i) begin : check_codes
    res_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (code_q.size() == 0) begin
        note_mismatch($sformatf("unexpected word byte %h last %b overflow %b",
                                out_byte_o, last_byte_o, overflow_o));
      end else begin
        due = code_q.pop_front();
        if (out_byte_o !== due.data)
          note_mismatch($sformatf("out_byte %h, want %h", out_byte_o, due.data));
        if (last_byte_o !== due.last)
          note_mismatch($sformatf("last_byte %b, want %b", last_byte_o, due.last));
        if (overflow_o !== due.ovf)
          note_mismatch($sformatf("overflow %b, want %b", overflow_o, due.ovf));
      end
    end
  end

  task automatic apb_write(input logic [CAP_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= APB_DATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read(output logic [APB_DATA_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CAP_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    v = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Waits until every pixel is sent and every owed word has come, then lets
  // the pipeline run dry, since a pixel may still be in flight without
  // producing a byte.
  task automatic settle(input int quiet);
    while (pixel_q.size() != 0 || in_valid_i || code_q.size() != 0) @(posedge clk_i);
    repeat (quiet) @(posedge clk_i);
  endtask

  // The capacity only changes while the packer is idle; each write is read
  // back.
  task automatic set_capacity(input logic [CAP_W-1:0] v);
    logic [APB_DATA_W-1:0] rd;
    settle(8);
    apb_write(v);
    cap_reg = v;
    apb_read(rd);
    if (rd[CAP_W-1:0] !== v)
      note_mismatch($sformatf("capacity reads %h, want %h", rd[CAP_W-1:0], v));
  endtask

  // Queues one frame built from runs of equal pixels: mostly short runs,
  // some medium, a few near or past the run limit. Some frames are plain noise, but
  // never one that is asked to open with a given run.
  // Returns the number of pixels queued.
  function automatic int queue_frame(input int first_run);
    pixel_word_t w;
    int          n_runs;
    int          len;
    int          pick;
    int          total;
    total = 0;
    w     = '0;
    if (first_run == 0 && $urandom_range(99) < 20) begin
      len = $urandom_range(10, 1);
      for (int i = 0; i < len; i++) begin
        w.pix = PIX_W'($urandom_range(15));
        pixel_q.push_back(w);
      end
      total = len;
    end else begin
      n_runs = $urandom_range(6, 1);
      for (int r = 0; r < n_runs; r++) begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(3, 1);
        else if (pick < 90) len = $urandom_range(12, 4);
        else len = $urandom_range(40, 28);
        if (r == 0 && first_run > 0) len = first_run;
        w.pix = PIX_W'($urandom_range(15));
        repeat (len) pixel_q.push_back(w);
        total += len;
      end
    end
    pixel_q[pixel_q.size() - 1].fend = 1'b1;
    return total;
  endfunction

  localparam logic [CAP_W-1:0] PHASE_CAP [6] = '{
    16'hFFFF, 16'd6, 16'd0, 16'd1, 16'd20, CAP_W'(CAP_RESET)
  };

  initial begin : run_test
    logic [APB_DATA_W-1:0] rd;
    logic [CAP_W-1:0]      cap;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // After reset the capacity holds its default.
    apb_read(rd);
    if (rd[CAP_W-1:0] !== CAP_W'(CAP_RESET))
      note_mismatch($sformatf("capacity after reset %h", rd[CAP_W-1:0]));

    for (int i = 0; i < DIR_N; i++) begin
      if (i == DIR_CAP_ZERO_AT) set_capacity('0);
      if (i == DIR_CAP_ONE_AT) set_capacity(CAP_W'(1));
      pixel_q.push_back(dir_tab[i]);
    end

    // One random frame under each of several capacities, from the full range
    // down to none. The first frame opens with a run one past the limit, so
    // that a full run token goes out and the same value starts a new run.
    for (int p = 0; p < 6; p++) begin
      cap = (p == 4) ? CAP_W'($urandom_range(40, 2)) : PHASE_CAP[p];
      set_capacity(cap);
      void'(queue_frame((p == 0) ? MAX_RUN_EXTRA + 2 : 0));
    end

    settle(24);
    if (n_bad == 0 && code_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/nrbp_pkg.sv
hw/rtl/nibble_rle_bit_packer.sv
test/tb.sv
